// File: hw/rtl/tdfim_pkg.sv
// Shared types and constants of the tensor depth fold index map.
package tdfim_pkg;

	localparam int SIZE_W = 16;
	localparam int HW_W = 2 * SIZE_W;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;

	localparam logic [2:0] REG_BATCH = 3'd0;
	localparam logic [2:0] REG_CHANNELS = 3'd1;
	localparam logic [2:0] REG_DEPTH = 3'd2;
	localparam logic [2:0] REG_HEIGHT = 3'd3;
	localparam logic [2:0] REG_WIDTH = 3'd4;

	typedef logic [SIZE_W-1:0] size_t;

	typedef struct packed {
		size_t batch;
		size_t channels;
		size_t depth;
		size_t height;
		size_t width;
	} sizes_t;

endpackage

// File: hw/rtl/tdfim_if.sv
// Handshake channel interfaces for element indexes and mapped results.
interface tdfim_req_if #(parameter int INDEX_BITS = 31);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] element_index;

	modport source(output valid, output element_index, input ready);
	modport sink(input valid, input element_index, output ready);
endinterface

interface tdfim_rsp_if #(parameter int INDEX_BITS = 31);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] target_index;
	logic                  index_out_of_range;

	modport source(output valid, output target_index, output index_out_of_range, input ready);
	modport sink(input valid, input target_index, input index_out_of_range, output ready);
endinterface

// File: hw/rtl/tdfim_cfg.sv
// Size registers with APB access and the derived slice size and element count.
module tdfim_cfg #(
	parameter int INDEX_BITS = 31
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tdfim_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [tdfim_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [tdfim_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	output tdfim_pkg::sizes_t                   sizes,
	output logic [tdfim_pkg::HW_W-1:0]          slice_size,
	output logic [INDEX_BITS:0]                 count
);
	import tdfim_pkg::*;

	localparam logic [INDEX_BITS:0] LIMIT = {1'b1, {INDEX_BITS{1'b0}}};

	sizes_t                  sizes_q;
	logic [HW_W-1:0]         hw_q;
	logic [HW_W-1:0]         nc_q;
	logic [HW_W-1:0]         dh_q;
	logic [INDEX_BITS:0]     ncdh_q;
	logic [INDEX_BITS:0]     count_q;
	logic [2*HW_W-1:0]       ncdh_full;
	logic [INDEX_BITS+SIZE_W:0] count_full;
	logic                    wr_en;
	logic [2:0]              reg_sel;

	assign reg_sel = paddr[4:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sizes_q <= '{batch: 16'd1, channels: 16'd1, depth: 16'd1, height: 16'd1,
				width: 16'd1};
		end else if (wr_en) begin
			case (reg_sel)
				REG_BATCH:    sizes_q.batch <= pwdata[SIZE_W-1:0];
				REG_CHANNELS: sizes_q.channels <= pwdata[SIZE_W-1:0];
				REG_DEPTH:    sizes_q.depth <= pwdata[SIZE_W-1:0];
				REG_HEIGHT:   sizes_q.height <= pwdata[SIZE_W-1:0];
				REG_WIDTH:    sizes_q.width <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_BATCH:    prdata = APB_DATA_W'(sizes_q.batch);
			REG_CHANNELS: prdata = APB_DATA_W'(sizes_q.channels);
			REG_DEPTH:    prdata = APB_DATA_W'(sizes_q.depth);
			REG_HEIGHT:   prdata = APB_DATA_W'(sizes_q.height);
			REG_WIDTH:    prdata = APB_DATA_W'(sizes_q.width);
			default:      prdata = '0;
		endcase
	end

	// The count is built through registers: sizes_q, then nc_q and dh_q, then ncdh_q, then count_q.
	assign ncdh_full = (2*HW_W)'(nc_q) * (2*HW_W)'(dh_q);
	assign count_full = (INDEX_BITS+SIZE_W+1)'(ncdh_q) * (INDEX_BITS+SIZE_W+1)'(sizes_q.width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= HW_W'(1);
			nc_q <= HW_W'(1);
			dh_q <= HW_W'(1);
			ncdh_q <= (INDEX_BITS+1)'(1);
			count_q <= (INDEX_BITS+1)'(1);
		end else begin
			hw_q <= HW_W'(sizes_q.height) * HW_W'(sizes_q.width);
			nc_q <= HW_W'(sizes_q.batch) * HW_W'(sizes_q.channels);
			dh_q <= HW_W'(sizes_q.depth) * HW_W'(sizes_q.height);
			ncdh_q <= (ncdh_full > (2*HW_W)'(LIMIT)) ? LIMIT : ncdh_full[INDEX_BITS:0];
			count_q <= (count_full > (INDEX_BITS+SIZE_W+1)'(LIMIT)) ? LIMIT
				: count_full[INDEX_BITS:0];
		end
	end

	assign sizes = sizes_q;
	assign slice_size = hw_q;
	assign count = count_q;
endmodule

// File: hw/rtl/tdfim_range.sv
// Entry stages that hold each index until the element count has settled, then flag it.
module tdfim_range #(
	parameter int INDEX_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [INDEX_BITS-1:0] in_index,
	input  logic [INDEX_BITS:0]   count,
	output logic                  out_valid,
	output logic [INDEX_BITS-1:0] held_index,
	output logic                  out_oor
);
	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [INDEX_BITS-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic                  oor_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= in_index;
			idx_s2 <= idx_s1;
			idx_s3 <= idx_s2;
			idx_s4 <= idx_s3;
			oor_s4 <= ({1'b0, idx_s3} >= count);
		end
	end

	assign out_valid = v_s4;
	assign held_index = idx_s4;
	assign out_oor = oor_s4;
endmodule

// File: hw/rtl/tdfim_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
module tdfim_div #(
	parameter int DIVIDEND_W = 31,
	parameter int DIVISOR_W = 16,
	parameter int SIDE_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	input  logic [SIDE_W-1:0]     in_side,
	output logic                  out_valid,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [DIVISOR_W-1:0]  remainder,
	output logic [SIDE_W-1:0]     out_side
);
	// Each stage shifts one dividend bit out of the top of dq and one quotient bit in.
	logic                  v_s   [DIVIDEND_W+1];
	logic [DIVIDEND_W-1:0] dq_s  [DIVIDEND_W+1];
	logic [DIVISOR_W-1:0]  rem_s [DIVIDEND_W+1];
	logic [SIDE_W-1:0]     side_s[DIVIDEND_W+1];

	assign v_s[0] = in_valid;
	assign dq_s[0] = dividend;
	assign rem_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < DIVIDEND_W; k++) begin : g_stage
		logic [DIVISOR_W:0] trial;
		logic               ge;
		logic [DIVISOR_W:0] diff;

		assign trial = {rem_s[k], dq_s[k][DIVIDEND_W-1]};
		assign ge = trial >= {1'b0, divisor};
		assign diff = trial - {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
				dq_s[k+1] <= {dq_s[k][DIVIDEND_W-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[DIVIDEND_W];
	assign quotient = dq_s[DIVIDEND_W];
	assign remainder = rem_s[DIVIDEND_W];
	assign out_side = side_s[DIVIDEND_W];
endmodule

// File: hw/rtl/tdfim_compose.sv
// Rebuilds the folded linear index from the split coordinates in four stages.
module tdfim_compose #(
	parameter int INDEX_BITS = 31
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_valid,
	input  logic [INDEX_BITS-1:0]            n,
	input  logic [tdfim_pkg::SIZE_W-1:0]     c,
	input  logic [tdfim_pkg::SIZE_W-1:0]     d,
	input  logic [tdfim_pkg::HW_W-1:0]       r,
	input  logic                             oor,
	input  tdfim_pkg::sizes_t                sizes,
	input  logic [tdfim_pkg::HW_W-1:0]       slice_size,
	output logic                             out_valid,
	output logic [INDEX_BITS-1:0]            target,
	output logic                             out_oor
);
	import tdfim_pkg::*;

	localparam int MW = INDEX_BITS + SIZE_W;
	localparam int PW = INDEX_BITS + HW_W;

	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [INDEX_BITS-1:0] m1_s1, m2_s2, pl_s3, ph_s3, t_s4;
	logic [SIZE_W-1:0]     c_s1;
	logic [HW_W-1:0]       r_s1, r_s2, r_s3;
	logic                  oor_s1, oor_s2, oor_s3, oor_s4;
	logic [MW-1:0]         nd, mc, pl, ph;
	logic [PW-1:0]         sum;

	assign nd = MW'(n) * MW'(sizes.depth) + MW'(d);
	assign mc = MW'(m1_s1) * MW'(sizes.channels) + MW'(c_s1);
	assign pl = MW'(m2_s2) * MW'(slice_size[SIZE_W-1:0]);
	assign ph = MW'(m2_s2) * MW'(slice_size[HW_W-1:SIZE_W]);
	assign sum = PW'(pl_s3) + (PW'(ph_s3) << SIZE_W) + PW'(r_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s1 <= nd[INDEX_BITS-1:0];
			c_s1 <= c;
			r_s1 <= r;
			oor_s1 <= oor;
			m2_s2 <= mc[INDEX_BITS-1:0];
			r_s2 <= r_s1;
			oor_s2 <= oor_s1;
			pl_s3 <= pl[INDEX_BITS-1:0];
			ph_s3 <= ph[INDEX_BITS-1:0];
			r_s3 <= r_s2;
			oor_s3 <= oor_s2;
			t_s4 <= oor_s3 ? '0 : sum[INDEX_BITS-1:0];
			oor_s4 <= oor_s3;
		end
	end

	assign out_valid = v_s4;
	assign target = t_s4;
	assign out_oor = oor_s4;
endmodule

// File: hw/rtl/tensor_depth_fold_index_map_top.sv
// Top level of the tensor depth fold index map: registers, range check, dividers, compose.
// Maps a linear element index of an N,C,D,H,W tensor to the index of the same element in
// the (N*D),C,H,W layout, so one mapping drives both the forward scatter and the backward
// gather. The block takes one item per cycle and returns one result per item, in order.
// The pipeline is built from these stages, in the order an item passes through them: four
// entry stages that also compare the index against the element count, three restoring
// dividers with one quotient bit per stage (by H*W, then by D, then by C), and four stages
// that multiply the coordinates back together. The whole pipeline advances whenever the
// result register is empty or being taken, so a stall on the output holds every stage.
// Sizes are written over the APB port at byte addresses 0, 4, 8, 12 and 16 (N, C, D, H, W)
// and must only change while no item is in flight. An index at or beyond N*C*D*H*W, which
// includes every index when a size is zero, returns target 0 with index_out_of_range set.
module tensor_depth_fold_index_map_top #(
	parameter int INDEX_BITS = 31
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tdfim_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [tdfim_pkg::APB_DATA_W-1:0] pwdata,
	output logic [tdfim_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready,
	tdfim_req_if.sink                        req,
	tdfim_rsp_if.source                      rsp
);
	import tdfim_pkg::*;

	sizes_t                sizes;
	logic [HW_W-1:0]       slice_size;
	logic [INDEX_BITS:0]   count;
	logic                  adv;

	logic                  rng_valid;
	logic [INDEX_BITS-1:0] rng_index;
	logic                  rng_oor;

	logic                  d1_valid;
	logic [INDEX_BITS-1:0] d1_quot;
	logic [HW_W-1:0]       d1_rem;
	logic                  d1_oor;

	logic                  d2_valid;
	logic [INDEX_BITS-1:0] d2_quot;
	logic [SIZE_W-1:0]     d2_rem;
	logic [HW_W:0]         d2_side;

	logic                  d3_valid;
	logic [INDEX_BITS-1:0] d3_quot;
	logic [SIZE_W-1:0]     d3_rem;
	logic [HW_W+SIZE_W:0]  d3_side;

	// Every stage moves together; the last compose stage is the output register.
	assign adv = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	tdfim_cfg #(.INDEX_BITS(INDEX_BITS)) u_cfg (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.sizes(sizes), .slice_size(slice_size), .count(count)
	);

	tdfim_range #(.INDEX_BITS(INDEX_BITS)) u_range (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(req.valid), .in_index(req.element_index), .count(count),
		.out_valid(rng_valid), .held_index(rng_index), .out_oor(rng_oor)
	);

	// Dividing by H*W leaves h*W+w as the remainder, which the compose stages add back as is.
	tdfim_div #(.DIVIDEND_W(INDEX_BITS), .DIVISOR_W(HW_W), .SIDE_W(1)) u_div_hw (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(rng_valid), .dividend(rng_index), .divisor(slice_size), .in_side(rng_oor),
		.out_valid(d1_valid), .quotient(d1_quot), .remainder(d1_rem), .out_side(d1_oor)
	);

	tdfim_div #(.DIVIDEND_W(INDEX_BITS), .DIVISOR_W(SIZE_W), .SIDE_W(HW_W+1)) u_div_d (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(d1_valid), .dividend(d1_quot), .divisor(sizes.depth),
		.in_side({d1_oor, d1_rem}),
		.out_valid(d2_valid), .quotient(d2_quot), .remainder(d2_rem), .out_side(d2_side)
	);

	tdfim_div #(.DIVIDEND_W(INDEX_BITS), .DIVISOR_W(SIZE_W), .SIDE_W(HW_W+SIZE_W+1)) u_div_c (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(d2_valid), .dividend(d2_quot), .divisor(sizes.channels),
		.in_side({d2_side, d2_rem}),
		.out_valid(d3_valid), .quotient(d3_quot), .remainder(d3_rem), .out_side(d3_side)
	);

	tdfim_compose #(.INDEX_BITS(INDEX_BITS)) u_compose (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(d3_valid), .n(d3_quot), .c(d3_rem),
		.d(d3_side[SIZE_W-1:0]), .r(d3_side[HW_W+SIZE_W-1:SIZE_W]),
		.oor(d3_side[HW_W+SIZE_W]),
		.sizes(sizes), .slice_size(slice_size),
		.out_valid(rsp.valid), .target(rsp.target_index), .out_oor(rsp.index_out_of_range)
	);

	// A flagged result never carries a target.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.index_out_of_range |-> rsp.target_index == '0)
		else $error("flagged result has a nonzero target");

	// With any size zero the element count is zero, so every result is flagged.
	a_zero_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (sizes.batch == '0 || sizes.channels == '0 || sizes.depth == '0 ||
			sizes.height == '0 || sizes.width == '0) |-> rsp.index_out_of_range)
		else $error("zero size gave an unflagged result");

	// A held result blocks new items until it is taken.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("input accepted while the output is stalled");
endmodule

// File: dv/tb_tensor_depth_fold_index_map_top.sv
// Testbench for the tensor depth fold index map: directed and random indexes, checked in order.
module tb_tensor_depth_fold_index_map_top;
	import tdfim_pkg::*;

	localparam int IB = 31;
	localparam int LATENCY = 3 * IB + 8;
	localparam int WATCHDOG_LIMIT = 20000;

	// Expected mapped result of one element index.
	typedef struct {
		logic [IB-1:0] target;
		logic          oor;
	} mapped_t;

	// Holds the mapped results still owed by the block and compares each arrival
	// with the oldest one, in order.
	class fold_scoreboard;
		mapped_t pending[$];
		int      errors;
		longint  n_size, c_size, d_size, h_size, w_size;

		function void set_sizes(sizes_t s);
			n_size = s.batch;
			c_size = s.channels;
			d_size = s.depth;
			h_size = s.height;
			w_size = s.width;
		endfunction

		// Count of elements, saturated just past the largest index.
		function longint element_count();
			longint lim, cnt;
			lim = longint'(1) << IB;
			cnt = 1;
			cnt = cnt * n_size; if (cnt > lim) cnt = lim;
			cnt = cnt * c_size; if (cnt > lim) cnt = lim;
			cnt = cnt * d_size; if (cnt > lim) cnt = lim;
			cnt = cnt * h_size; if (cnt > lim) cnt = lim;
			cnt = cnt * w_size; if (cnt > lim) cnt = lim;
			return cnt;
		endfunction

		function void note_index(logic [IB-1:0] idx);
			mapped_t m;
			longint rest, w, h, d, c, t;
			if (longint'(idx) >= element_count()) begin
				m.target = '0;
				m.oor = 1'b1;
			end else begin
				// Split into coordinates, then rebuild with depth folded into batch.
				rest = idx;
				w = rest % w_size; rest = rest / w_size;
				h = rest % h_size; rest = rest / h_size;
				d = rest % d_size; rest = rest / d_size;
				c = rest % c_size; rest = rest / c_size;
				t = rest * d_size + d;
				t = t * c_size + c;
				t = t * h_size + h;
				t = t * w_size + w;
				m.target = t[IB-1:0];
				m.oor = 1'b0;
			end
			pending.insert(pending.size(), m);
		endfunction

		task report_mismatch(string what, longint exp_v, longint got_v);
			$display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
			errors++;
		endtask

		task check_result(logic [IB-1:0] target, logic oor);
			mapped_t m;
			if (pending.size() == 0) begin
				report_mismatch("result with nothing expected", 0, target);
				return;
			end
			m = pending.pop_front();
			if (oor !== m.oor)
				report_mismatch("index_out_of_range", m.oor, oor);
			if (target !== m.target)
				report_mismatch("target_index", m.target, target);
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	tdfim_req_if #(.INDEX_BITS(IB)) req();
	tdfim_rsp_if #(.INDEX_BITS(IB)) rsp();

	tensor_depth_fold_index_map_top #(.INDEX_BITS(IB)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.req    (req),
		.rsp    (rsp)
	);

	fold_scoreboard sb;

	// Receiver control: random stalls in the middle, none at the end, plus one long hold.
	bit  rx_stalls_on;
	bit  rx_long_hold;
	int  idle_cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Writes one size register through a setup and an access phase, then returns the bus to idle.
	task automatic write_size(logic [2:0] reg_id, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(reg_id) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Loads all five sizes; the predictor keeps only the low 16 bits, as the block does.
	task automatic load_sizes(sizes_t s, logic [15:0] upper_junk);
		write_size(REG_BATCH, {upper_junk, s.batch});
		write_size(REG_CHANNELS, {upper_junk, s.channels});
		write_size(REG_DEPTH, {upper_junk, s.depth});
		write_size(REG_HEIGHT, {upper_junk, s.height});
		write_size(REG_WIDTH, {upper_junk, s.width});
		sb.set_sizes(s);
	endtask

	// Waits for every owed result, then lets the pipeline drain before any size change.
	task automatic drain_pipeline();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Offers one index and holds it until the block takes it, with an optional gap first.
	task automatic send_index(logic [IB-1:0] idx, bit allow_gap);
		if (allow_gap && $urandom_range(0, 7) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.element_index <= idx;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_index(idx);
	endtask

	task automatic end_burst();
		req.valid <= 1'b0;
	endtask

	// Picks an index that is mostly inside the tensor, sometimes at or past its end.
	function automatic logic [IB-1:0] pick_index();
		longint cnt;
		cnt = sb.element_count();
		case ($urandom_range(0, 9))
			0: return IB'($urandom());
			1: return (cnt > 0 && cnt < (longint'(1) << IB)) ? IB'(cnt) : IB'(0);
			2: return (cnt > 0) ? IB'(cnt - 1) : IB'(0);
			default: return (cnt > 0) ? IB'(longint'($urandom()) % cnt) : IB'($urandom());
		endcase
	endfunction

	function automatic sizes_t random_sizes();
		sizes_t s;
		s.batch = 16'($urandom_range(1, 9));
		s.channels = 16'($urandom_range(1, 9));
		s.depth = 16'($urandom_range(1, 9));
		s.height = 16'($urandom_range(1, 20));
		s.width = 16'($urandom_range(1, 20));
		if ($urandom_range(0, 5) == 0) s.width = 16'($urandom());
		if ($urandom_range(0, 5) == 0) s.height = 16'($urandom());
		return s;
	endfunction

	// Result side: checks each accepted result.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result(rsp.target_index, rsp.index_out_of_range);
	end

	// Result side: drives ready with random stalls and one long hold.
	initial begin
		int stall;
		bit long_hold_done;
		long_hold_done = 1'b0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_long_hold && !long_hold_done) begin
				rsp.ready <= 1'b0;
				stall = 0;
				while (stall < 300) begin
					@(posedge clk);
					stall++;
				end
				long_hold_done = 1'b1;
				rsp.ready <= 1'b1;
			end else if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Watchdog: counts cycles with no handshake on either channel and no APB select.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("tb_tensor_depth_fold_index_map_top: FAIL");
			$finish;
		end
	end

	initial begin
		sizes_t s;
		logic [IB-1:0] idx;
		int n_items;
		sb = new();
		rx_stalls_on = 1'b0;
		rx_long_hold = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.element_index = '0;
		s = '{batch: 16'd1, channels: 16'd1, depth: 16'd1, height: 16'd1, width: 16'd1};
		sb.set_sizes(s);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes are all one: only index zero lies inside the tensor.
		send_index('0, 0);
		send_index(IB'(1), 0);
		send_index('1, 0);
		end_burst();
		drain_pipeline();

		// A small tensor, with upper register bits set to show they are ignored.
		s = '{batch: 16'd2, channels: 16'd3, depth: 16'd4, height: 16'd5, width: 16'd6};
		load_sizes(s, 16'hFFFF);
		send_index('0, 0);
		send_index(IB'(1), 0);
		send_index(IB'(7), 0);
		send_index(IB'(119), 0);
		send_index(IB'(359), 0);
		send_index(IB'(719), 0);
		send_index(IB'(720), 0);
		send_index(IB'(12345), 0);
		end_burst();
		drain_pipeline();

		// A zero size makes every index out of range.
		s.depth = 16'd0;
		load_sizes(s, 16'h0000);
		send_index('0, 0);
		send_index(IB'(5), 0);
		send_index('1, 0);
		end_burst();
		drain_pipeline();

		// All sizes at their maximum: the count saturates and nothing is flagged.
		s = '{batch: 16'hFFFF, channels: 16'hFFFF, depth: 16'hFFFF, height: 16'hFFFF,
			width: 16'hFFFF};
		load_sizes(s, 16'hA5A5);
		send_index('0, 0);
		send_index('1, 0);
		send_index(IB'(31'h2AAA_AAAA), 0);
		send_index(IB'(31'h5555_5555), 0);
		send_index(IB'(65536), 0);
		end_burst();
		drain_pipeline();

		// Random phases; stalls on both sides, with one long hold on the receiver.
		// The phase with the long hold sends more items than the pipeline holds.
		rx_stalls_on = 1'b1;
		for (int phase = 0; phase < 24; phase++) begin
			load_sizes(random_sizes(), 16'($urandom()));
			n_items = (phase == 3) ? 200 : 58;
			if (phase == 3)
				rx_long_hold = 1'b1;
			if (phase == 21)
				rx_stalls_on = 1'b0;
			for (int k = 0; k < n_items; k++) begin
				idx = pick_index();
				send_index(idx, phase < 21);
			end
			end_burst();
			// The sender waits for every result here before the next sizes.
			drain_pipeline();
		end

		if (sb.errors == 0)
			$display("tb_tensor_depth_fold_index_map_top: PASS");
		else
			$display("tb_tensor_depth_fold_index_map_top: FAIL");
		$finish;
	end

endmodule
